// File: rtl/core/echo_pulse_ranger_median5_defines.svh
// Assertion macros used by the echo ranger top level.
`ifndef ECHO_PULSE_RANGER_MEDIAN5_DEFINES_SVH
`define ECHO_PULSE_RANGER_MEDIAN5_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define EPR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("epr: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define EPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("epr: next-cycle check failed");

`endif

// File: rtl/core/epr_pkg.sv
// Shared types and constants for the echo ranger.
`timescale 1ns / 1ps
`default_nettype none

package epr_pkg;

  localparam int unsigned DIST_W       = 11;
  localparam int unsigned WIN_DEPTH    = 5;
  localparam int unsigned TICKS_PER_CM = 58;

  // Pulse widths at or above this give a quotient that no limit can pass.
  localparam int unsigned DIFF_CAP     = TICKS_PER_CM * (1 << DIST_W);
  localparam int unsigned QDIFF_W      = $clog2(DIFF_CAP);

  // diff/58 == (diff>>1)/29, done as a reciprocal multiply on the halved value
  localparam int unsigned HALF_DIV     = TICKS_PER_CM / 2;
  localparam int unsigned HALF_W       = QDIFF_W - 1;
  localparam int unsigned RECIP_SHIFT  = HALF_W + $clog2(HALF_DIV);
  localparam int unsigned RECIP_M      = ((1 << RECIP_SHIFT) + HALF_DIV - 1) / HALF_DIV;
  localparam int unsigned RECIP_W      = $clog2(RECIP_M + 1);
  localparam int unsigned PROD_W       = HALF_W + RECIP_W;

  // APB register map
  localparam int unsigned CFG_ADDR_W   = 3;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam logic        CFG_IDX_MAX_DISTANCE = 1'b0;
  localparam logic [DIST_W-1:0] MAX_DISTANCE_RST = DIST_W'(400);

  typedef logic [DIST_W-1:0]  dist_t;
  typedef dist_t [WIN_DEPTH-1:0] win_t;
  typedef logic [QDIFF_W-1:0] qdiff_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/epr_if.sv
// Stream interfaces for capture events and ranging results.
`timescale 1ns / 1ps
`default_nettype none

interface epr_in_if #(
  parameter int unsigned TIMER_WIDTH = 16
) ();
  logic                   valid;
  logic                   ready;
  logic                   echo_high;
  logic [TIMER_WIDTH-1:0] capture_count;

  modport source (output valid, echo_high, capture_count, input ready);
  modport sink   (input valid, echo_high, capture_count, output ready);
endinterface

interface epr_out_if ();
  logic                  valid;
  logic                  ready;
  logic [epr_pkg::DIST_W-1:0] distance_cm;
  logic [epr_pkg::DIST_W-1:0] median_cm;

  modport source (output valid, distance_cm, median_cm, input ready);
  modport sink   (input valid, distance_cm, median_cm, output ready);
endinterface

`default_nettype wire

// File: rtl/core/echo_pulse_ranger_median5.sv
// Echo ranger top level: wires front, queue, back end and the APB register.
//
// Usage:
//   in_ch carries capture beats (echo_high, capture_count). A beat with
//   echo_high set records the pulse start and yields no result. A beat with
//   echo_high clear ends the pulse: width/58 in cm, clamped to max_distance,
//   enters a five-deep window; out_ch carries one beat (distance_cm,
//   median_cm) for it.
//   max_distance sits at APB address 0 and must be written by the user only
//   while the block is idle; the block itself does not enforce this.
//   Throughput: one beat per cycle on both channels unless out_ch stalls;
//   the divide multiplier and median network each own one pipeline stage.
//   A two-entry queue separates the front from the back end; when out_ch
//   is stalled the back pipe holds, the queue fills and in_ch.ready drops.
//   Rising-edge beats are still taken only while the queue has room.
//   Reset (rst_n low, synchronous) clears the start count, the window
//   (to zero), the queue and all valid flags; max_distance returns to 400.
`timescale 1ns / 1ps
`default_nettype none
`include "echo_pulse_ranger_median5_defines.svh"

module echo_pulse_ranger_median5 #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  epr_in_if.sink                               in_ch,
  epr_out_if.source                            out_ch,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [epr_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [epr_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [epr_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                 pready
);

  epr_pkg::fifo_stat_t fifo_stat;
  logic                push;
  epr_pkg::qdiff_t     push_data;
  logic                pop;
  epr_pkg::qdiff_t     pop_data;

  epr_pkg::dist_t max_distance_r;
  epr_pkg::dist_t max_distance_nxt;
  logic           reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == epr_pkg::CFG_IDX_MAX_DISTANCE);

  always_comb begin
    max_distance_nxt = max_distance_r;
    if (psel && penable && pwrite && reg_hit) begin
      max_distance_nxt = pwdata[epr_pkg::DIST_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_hit) begin
      prdata = epr_pkg::CFG_DATA_W'(max_distance_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_distance_r <= epr_pkg::MAX_DISTANCE_RST;
    end else begin
      max_distance_r <= max_distance_nxt;
    end
  end

  epr_front #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .fifo_stat (fifo_stat),
    .push      (push),
    .push_data (push_data)
  );

  epr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (fifo_stat)
  );

  epr_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .fifo_stat    (fifo_stat),
    .pop_data     (pop_data),
    .pop          (pop),
    .max_distance (max_distance_r),
    .out_ch       (out_ch)
  );

  // a pulse-start beat never reaches the queue
  `EPR_ASSERT_IMPL(a_rise_no_push, clk, rst_n, in_ch.valid && in_ch.ready && in_ch.echo_high, !push)
  // the queue is never written while full
  `EPR_ASSERT_IMPL(a_no_overflow, clk, rst_n, fifo_stat.full, !push)
  // a pulse-end beat leaves the queue non-empty on the next cycle
  `EPR_ASSERT_NEXT(a_fall_queued, clk, rst_n, in_ch.valid && in_ch.ready && !in_ch.echo_high, !fifo_stat.empty)

endmodule

`default_nettype wire

// File: rtl/core/epr_front.sv
// Front end: takes capture beats, tracks the pulse start, forms the pulse width.
`timescale 1ns / 1ps
`default_nettype none

module epr_front #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  epr_in_if.sink                  in_ch,
  input  wire epr_pkg::fifo_stat_t fifo_stat,
  output logic                    push,
  output epr_pkg::qdiff_t         push_data
);

  localparam int unsigned CW = (TIMER_WIDTH > epr_pkg::QDIFF_W) ? TIMER_WIDTH
                                                               : epr_pkg::QDIFF_W;

  logic [TIMER_WIDTH-1:0] start_count_r;
  logic [TIMER_WIDTH-1:0] start_count_nxt;
  logic [TIMER_WIDTH-1:0] diff;
  logic [CW-1:0]          diff_ext;
  logic                   accept;

  assign in_ch.ready = !fifo_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;

  // absolute difference, no wrap
  assign diff = (in_ch.capture_count > start_count_r) ? in_ch.capture_count - start_count_r
                                                      : start_count_r - in_ch.capture_count;
  assign diff_ext = CW'(diff);

  always_comb begin
    push_data = epr_pkg::QDIFF_W'(diff_ext);
    if (diff_ext >= CW'(epr_pkg::DIFF_CAP)) begin
      push_data = epr_pkg::QDIFF_W'(epr_pkg::DIFF_CAP - 1);
    end
  end

  assign push            = accept && !in_ch.echo_high;
  assign start_count_nxt = (accept && in_ch.echo_high) ? in_ch.capture_count : start_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_count_r <= '0;
    end else begin
      start_count_r <= start_count_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/epr_fifo.sv
// Two-entry queue of pulse widths between front and back end.
`timescale 1ns / 1ps
`default_nettype none

module epr_fifo (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire epr_pkg::qdiff_t     push_data,
  input  wire logic                pop,
  output epr_pkg::qdiff_t          pop_data,
  output epr_pkg::fifo_stat_t      stat
);

  localparam int unsigned DEPTH = 2;

  epr_pkg::qdiff_t mem_r [DEPTH];
  logic            wr_ptr_r;
  logic            rd_ptr_r;
  logic [1:0]      count_r;
  logic [1:0]      count_nxt;

  assign stat.full  = (count_r == 2'(DEPTH));
  assign stat.empty = (count_r == 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/epr_back.sv
// Back end: divide by 58, clamp, window shift and median-of-five, result register.
`timescale 1ns / 1ps
`default_nettype none

module epr_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire epr_pkg::fifo_stat_t fifo_stat,
  input  wire epr_pkg::qdiff_t     pop_data,
  output logic                     pop,
  input  wire epr_pkg::dist_t      max_distance,
  epr_out_if.source                out_ch
);

  localparam int unsigned NUM_CMP = 8;
  localparam logic [2:0] PAIR_LO [NUM_CMP] = '{3'd0, 3'd3, 3'd0, 3'd1, 3'd0, 3'd2, 3'd1, 3'd1};
  localparam logic [2:0] PAIR_HI [NUM_CMP] = '{3'd1, 3'd4, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4, 3'd2};
  localparam logic [2:0] MEDIAN_IDX = 3'd2;

  function automatic epr_pkg::dist_t median5(input epr_pkg::win_t w);
    epr_pkg::dist_t v [epr_pkg::WIN_DEPTH];
    epr_pkg::dist_t t;
    for (int i = 0; i < epr_pkg::WIN_DEPTH; i++) begin
      v[i] = w[i];
    end
    // compare-swap network, fixed order
    for (int k = 0; k < NUM_CMP; k++) begin
      if (v[PAIR_LO[k]] > v[PAIR_HI[k]]) begin
        t              = v[PAIR_LO[k]];
        v[PAIR_LO[k]]  = v[PAIR_HI[k]];
        v[PAIR_HI[k]]  = t;
      end
    end
    return v[MEDIAN_IDX];
  endfunction

  logic                        adv;
  logic [epr_pkg::PROD_W-1:0]  prod;
  epr_pkg::dist_t              q_clamped;

  logic            s1_valid_r;
  epr_pkg::dist_t  q_r;
  logic            s2_valid_r;
  epr_pkg::dist_t  dist_r;
  epr_pkg::win_t   win_r;
  epr_pkg::win_t   win_nxt;
  logic            out_valid_r;
  epr_pkg::dist_t  out_dist_r;
  epr_pkg::dist_t  out_med_r;

  // whole back pipe moves together unless the result register is held
  assign adv = !out_valid_r || out_ch.ready;
  assign pop = adv && !fifo_stat.empty;

  assign prod = epr_pkg::PROD_W'(pop_data[epr_pkg::QDIFF_W-1:1])
              * epr_pkg::PROD_W'(epr_pkg::RECIP_M);

  assign q_clamped = (q_r > max_distance) ? max_distance : q_r;
  assign win_nxt   = {win_r[epr_pkg::WIN_DEPTH-2:0], q_clamped};

  assign out_ch.valid       = out_valid_r;
  assign out_ch.distance_cm = out_dist_r;
  assign out_ch.median_cm   = out_med_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      q_r <= prod[epr_pkg::RECIP_SHIFT +: epr_pkg::DIST_W];
      if (s1_valid_r) begin
        dist_r <= q_clamped;
      end
      if (s2_valid_r) begin
        out_dist_r <= dist_r;
        out_med_r  <= median5(win_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      win_r       <= '0;
    end else if (adv) begin
      s1_valid_r  <= pop;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
      if (s1_valid_r) begin
        win_r <= win_nxt;
      end
    end
  end

endmodule

`default_nettype wire
